@@ design/bba_pkg.sv @@
// Shared types and fixed field widths for the block bitmap allocator.
// No dependencies; every other design file except bba_ram imports this package.
package bba_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    localparam int STAT_W  = 2;
    localparam int DISK_W  = 16;
    localparam int CLAMP_W = DISK_W + 1;
    localparam int WORD_W  = 32;
    localparam int BIT_W   = 5;

    localparam logic [DISK_W-1:0] DISK_RESET = 16'd4096;

    typedef enum logic [CMD_W-1:0] {
        CMD_FORMAT = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_CHECK  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_ALREADY = 2'd1,
        ST_ERR     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FMT,
        S_SCAN,
        S_FREE,
        S_DONE
    } t_state;

endpackage

@@ design/bba_if.sv @@
// Valid/ready channel interfaces: command, result and configuration write.
// Depends on bba_pkg for field widths.
interface bba_cmd_if import bba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   block_index;

    modport source (output valid, output command, output block_index, input ready);
    modport sink   (input valid, input command, input block_index, output ready);
endinterface

interface bba_res_if import bba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   alloc_index;
    logic [CNT_W-1:0]   free_count;
    logic [CNT_W-1:0]   used_count;

    modport source (output valid, output status, output alloc_index, output free_count,
                    output used_count, input ready);
    modport sink   (input valid, input status, input alloc_index, input free_count,
                    input used_count, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DISK_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/bba_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/block_bitmap_allocator_core.sv @@
// Block bitmap allocator top level: FSM, counters and the bitmap RAM.
// Depends on bba_pkg, the channel interfaces in bba_if and bba_ram.
//
//  channel | dir | payload                                      | role
//  --------+-----+----------------------------------------------+---------------------
//  i_cmd   | in  | command, block_index                         | one command each
//  o_res   | out | status, alloc_index, free_count, used_count  | one result each
//  i_cfg   | in  | data (disk_blocks)                           | disk size, any time
//
// One command at a time. Check needs no RAM access; free does one RAM read and one
// write back (the write only if the block was in use); format writes one bitmap word per
// cycle; allocate reads one word per cycle from the RAM read port, from the first unreserved word.
// A finished result sits in the output register; the next command is taken while it waits.
// Synchronous active-low reset clears the counts and state; the bitmap reads as all zero
// until the first successful format, so no clearing pass follows reset.
// A stalled result holds the block in its completion state until the output slot frees.
module block_bitmap_allocator_core
    import bba_pkg::*;
#(
    parameter int MAP_WORDS       = 128,
    parameter int RESERVED_BLOCKS = 131
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    bba_cmd_if.sink   i_cmd,
    bba_res_if.source o_res,
    bba_cfg_if.sink   i_cfg
);

    localparam int AW       = $clog2(MAP_WORDS);
    localparam int BLK_W    = AW + BIT_W;
    localparam int CAPACITY = MAP_WORDS * WORD_W;
    localparam int RES_BITS = RESERVED_BLOCKS % WORD_W;

    localparam logic [CLAMP_W-1:0] CAP_C    = CLAMP_W'(CAPACITY);
    localparam logic [CLAMP_W-1:0] RES_C    = CLAMP_W'(RESERVED_BLOCKS);
    localparam logic [IDX_W-1:0]   RES_IDX  = IDX_W'(RESERVED_BLOCKS);
    localparam logic [CNT_W-1:0]   RES_CNT  = CNT_W'(RESERVED_BLOCKS);
    localparam logic [AW-1:0]      W_FIRST  = AW'(RESERVED_BLOCKS / WORD_W);
    localparam logic [AW-1:0]      W_LAST   = AW'(MAP_WORDS - 1);
    localparam logic [WORD_W-1:0]  W_PART   = ~({WORD_W{1'b1}} >> RES_BITS);

    // control and state registers
    t_state              r_state, n_state;
    logic [AW-1:0]       r_word, n_word;
    logic [IDX_W-1:0]    r_idx, n_idx;
    t_status             r_status, n_status;
    logic [IDX_W-1:0]    r_aidx, n_aidx;
    logic [CNT_W-1:0]    r_free, n_free;
    logic [CNT_W-1:0]    r_used, n_used;
    logic [DISK_W-1:0]   r_disk;
    logic                r_formatted, n_formatted;

    // output register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [IDX_W-1:0]    r_out_aidx;
    logic [CNT_W-1:0]    r_out_free;
    logic [CNT_W-1:0]    r_out_used;

    // RAM port signals
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_wdata, ram_rdata;

    // decoded conditions
    logic                cmd_acc;
    logic                out_load;
    logic [CLAMP_W-1:0]  disk_n;
    logic                disk_ok;
    logic                idx_ok;
    logic [WORD_W-1:0]   rd_word;
    logic                has_zero;
    logic [BIT_W-1:0]    zpos;
    logic [CNT_W:0]      cnt_sum;
    logic [WORD_W-1:0]   fmt_word;
    logic [BLK_W-1:0]    blk_num;

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshakes
    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    // clamp disk size to map capacity
    assign disk_n  = ({1'b0, r_disk} > CAP_C) ? CAP_C : {1'b0, r_disk};
    assign disk_ok = disk_n > RES_C;
    assign idx_ok  = (i_cmd.block_index >= RES_IDX)
                     && ({{(CLAMP_W-IDX_W){1'b0}}, i_cmd.block_index} < CAP_C);
    assign cnt_sum = {1'b0, r_used} + {1'b0, r_free};

    // unformatted map reads as all zero
    assign rd_word  = r_formatted ? ram_rdata : '0;
    assign has_zero = ~&rd_word;

    // highest clear bit, i.e. the first free block in MSB-first order
    always_comb begin
        zpos = '0;
        for (int j = 0; j < WORD_W; j++) begin
            if (!rd_word[j]) begin
                zpos = BIT_W'(j);
            end
        end
    end

    assign blk_num = {r_word, ~zpos};

    // reserved-block pattern for the word being formatted
    always_comb begin
        priority if (r_word < W_FIRST) begin
            fmt_word = '1;
        end else if (r_word == W_FIRST) begin
            fmt_word = W_PART;
        end else begin
            fmt_word = '0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    unique case (t_cmd'(i_cmd.command))
                        CMD_FORMAT: n_state = disk_ok ? S_FMT : S_DONE;
                        CMD_ALLOC:  n_state = (r_free != '0) ? S_SCAN : S_DONE;
                        CMD_FREE:   n_state = idx_ok ? S_FREE : S_DONE;
                        CMD_CHECK:  n_state = S_DONE;
                    endcase
                end
            end
            S_FMT: begin
                if (r_word == W_LAST) n_state = S_DONE;
            end
            S_SCAN: begin
                if (has_zero || r_word == W_LAST) n_state = S_DONE;
            end
            S_FREE: n_state = S_DONE;
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        n_word      = r_word;
        n_idx       = r_idx;
        n_status    = r_status;
        n_aidx      = r_aidx;
        n_free      = r_free;
        n_used      = r_used;
        n_formatted = r_formatted;
        ram_we      = 1'b0;
        ram_waddr   = r_word;
        ram_wdata   = fmt_word;
        ram_re      = 1'b0;
        ram_raddr   = r_word;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    n_aidx = '0;
                    n_idx  = i_cmd.block_index;
                    unique case (t_cmd'(i_cmd.command))
                        CMD_FORMAT: begin
                            n_status = disk_ok ? ST_OK : ST_ERR;
                            n_word   = '0;
                        end
                        CMD_ALLOC: begin
                            n_status  = ST_ERR;
                            n_word    = W_FIRST;
                            ram_re    = (r_free != '0);
                            ram_raddr = W_FIRST;
                        end
                        CMD_FREE: begin
                            n_status  = idx_ok ? ST_OK : ST_ERR;
                            ram_re    = idx_ok;
                            ram_raddr = AW'(i_cmd.block_index >> BIT_W);
                        end
                        CMD_CHECK: begin
                            n_status = (disk_ok && {{(CLAMP_W-CNT_W-1){1'b0}}, cnt_sum} == disk_n)
                                       ? ST_OK : ST_ERR;
                        end
                    endcase
                end
            end
            S_FMT: begin
                // clear the map and mark the reserved leading blocks
                ram_we    = 1'b1;
                ram_waddr = r_word;
                ram_wdata = fmt_word;
                n_word    = r_word + 1'b1;
                if (r_word == W_LAST) begin
                    n_free      = CNT_W'(disk_n - RES_C);
                    n_used      = RES_CNT;
                    n_formatted = 1'b1;
                end
            end
            S_SCAN: begin
                // claim the first clear bit, or advance to the next word
                if (has_zero) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_word;
                    ram_wdata = rd_word | (WORD_W'(1) << zpos);
                    n_status  = ST_OK;
                    n_aidx    = IDX_W'(blk_num);
                    n_free    = r_free - 1'b1;
                    n_used    = r_used + 1'b1;
                end else if (r_word != W_LAST) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_word + 1'b1;
                    n_word    = r_word + 1'b1;
                end
            end
            S_FREE: begin
                // drop the bit, or report it as already free
                ram_waddr = AW'(r_idx >> BIT_W);
                ram_wdata = rd_word & ~(WORD_W'(1) << ~r_idx[BIT_W-1:0]);
                if (rd_word[~r_idx[BIT_W-1:0]]) begin
                    ram_we = 1'b1;
                    n_free = r_free + 1'b1;
                    n_used = r_used - 1'b1;
                end else begin
                    n_status = ST_ALREADY;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '0;
            r_used      <= '0;
            r_formatted <= 1'b0;
            r_disk      <= DISK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_used      <= n_used;
            r_formatted <= n_formatted;
            if (i_cfg.valid && i_cfg.ready) begin
                r_disk <= i_cfg.data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_aidx   <= n_aidx;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_aidx   <= (r_status == ST_OK) ? r_aidx : '0;
            r_out_free   <= r_free;
            r_out_used   <= r_used;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.alloc_index = r_out_aidx;
    assign o_res.free_count  = r_out_free;
    assign o_res.used_count  = r_out_used;

endmodule

@@ design/bba_checker.sv @@
// Port-level assertions for the block bitmap allocator, bound to the top level.
// Depends on bba_pkg and block_bitmap_allocator_core.
module bba_checker
    import bba_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cmd_valid,
    input logic              i_cmd_ready,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic [STAT_W-1:0] i_res_status,
    input logic [IDX_W-1:0]  i_res_alloc_index,
    input logic [CNT_W-1:0]  i_res_free_count,
    input logic [CNT_W-1:0]  i_res_used_count
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // a command holds the block busy for at least the next cycle
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> !i_cmd_ready)
        else $error("command taken while previous one still running");

    // a stalled result transaction holds its payload
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_status)
            && $stable(i_res_alloc_index) && $stable(i_res_free_count)
            && $stable(i_res_used_count)))
        else $error("stalled result changed");

    // a block number is only reported on success
    a_aidx_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_status != ST_OK) |-> (i_res_alloc_index == '0))
        else $error("alloc index set on a failed command");

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_valid       (i_cmd.valid),
    .i_cmd_ready       (i_cmd.ready),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_status      (o_res.status),
    .i_res_alloc_index (o_res.alloc_index),
    .i_res_free_count  (o_res.free_count),
    .i_res_used_count  (o_res.used_count)
);
